// ===== sv/serial_command_time_of_day_clock_defines.svh =====
// Assertion macros used by the clock top level.
`ifndef SERIAL_COMMAND_TIME_OF_DAY_CLOCK_DEFINES_SVH
`define SERIAL_COMMAND_TIME_OF_DAY_CLOCK_DEFINES_SVH
`define SCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCT_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// ===== sv/sctc_pkg.sv =====
// Package with constants, types and tables of the clock.
package sctc_pkg;
  localparam int unsigned FrameMax = 60;
  localparam logic [7:0] FrameMaxB = 8'(FrameMax);
  localparam logic [3:0] TextCut = (FrameMax - 1 > 15) ? 4'd15 : 4'(FrameMax - 1);
  localparam int unsigned CmdSlots = 14;
  localparam logic [7:0] TpsReset = 8'd50;
  localparam logic [7:0] ToReset = 8'd1;
  localparam logic REG_TPS = 1'b0;
  localparam logic REG_TO = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ADD  = 5'b00010,
    ST_FMT  = 5'b00100,
    ST_SEND = 5'b01000,
    ST_ERR  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } bcd_t;

  function automatic logic [7:0] err_char(input logic [3:0] i);
    logic [7:0] c;
    unique case (i)
      4'd0: c = "E";  4'd1: c = "r";  4'd2: c = "r";  4'd3: c = "o";
      4'd4: c = "r";  4'd5: c = " ";  4'd6: c = "C";  4'd7: c = "o";
      4'd8: c = "m";  4'd9: c = "m";  4'd10: c = "a"; 4'd11: c = "n";
      4'd12: c = "d"; default: c = "!";
    endcase
    return c;
  endfunction

  function automatic bcd_t to_bcd(input logic [5:0] v);
    bcd_t r;
    r.tens = 4'((12'(v) * 12'd52) >> 9);
    r.ones = 4'(v - 6'(r.tens) * 6'd10);
    return r;
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction
endpackage

// ===== sv/sctc_parse.sv =====
// Command text parser: prefix match, time field check and values.
module sctc_parse (
  input  logic [13:0][7:0] chars,
  input  logic [3:0]       text_length,
  output logic             is_get,
  output logic             is_set,
  output logic             is_inc,
  output logic             time_ok,
  output logic [4:0]       h,
  output logic [5:0]       m,
  output logic [5:0]       s
);
  logic pre;
  logic fmt;
  logic [6:0] hv, mv, sv;
  always_comb begin
    pre = chars[0] == "A" && chars[1] == "T" && chars[2] == "+";
    is_get = text_length == 4'd6 && pre && chars[3] == "G" && chars[4] == "E" &&
             chars[5] == "T";
    is_set = text_length == 4'd14 && pre && chars[3] == "S" && chars[4] == "E" &&
             chars[5] == "T";
    is_inc = text_length == 4'd14 && pre && chars[3] == "I" && chars[4] == "N" &&
             chars[5] == "C";
    fmt = sctc_pkg::is_dig(chars[6]) && sctc_pkg::is_dig(chars[7]) && chars[8] == ":" &&
          sctc_pkg::is_dig(chars[9]) && sctc_pkg::is_dig(chars[10]) &&
          chars[11] == ":" && sctc_pkg::is_dig(chars[12]) && sctc_pkg::is_dig(chars[13]);
    hv = 7'(chars[6][3:0]) * 7'd10 + 7'(chars[7][3:0]);
    mv = 7'(chars[9][3:0]) * 7'd10 + 7'(chars[10][3:0]);
    sv = 7'(chars[12][3:0]) * 7'd10 + 7'(chars[13][3:0]);
    time_ok = fmt && hv <= 7'd23 && mv <= 7'd59 && sv <= 7'd59;
    h = hv[4:0];
    m = mv[5:0];
    s = sv[5:0];
  end
endmodule

// ===== sv/serial_command_time_of_day_clock.sv =====
// Top level of the serial command time-of-day clock.
// A tick or byte that closes no frame, or that closes a valid SET command, leaves the clock idle.
// A GET reply passes the format state, then 8 byte transfers; INC first adds seconds, minutes
// and hours on the shared carry adder; the error text is 14 transfers right after the close.
// A low out_tready stalls the reply, and in_tready stays low until the last byte.
// Synchronous active-low reset clears time, counters and frame state and reloads the registers.
`include "serial_command_time_of_day_clock_defines.svh"
module serial_command_time_of_day_clock (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tlast,  // last
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);
  sctc_pkg::state_t st_r, st_nxt;
  logic [7:0] tps_r, to_r, div_r, fc_r, tc_r;
  logic [4:0] hr_r;
  logic [5:0] mn_r, sc_r;
  logic rcv_r, ended_r;
  logic [3:0] tl_r;
  logic [13:0][7:0] ch_r;
  logic [1:0] step_r;
  logic cy_r;
  logic [3:0] idx_r;
  logic [13:0][7:0] msg_r;
  logic is_get, is_set, is_inc, tok;
  logic [4:0] ph;
  logic [5:0] pm, ps;
  logic acc;
  logic [7:0] div_inc, tc_inc;
  logic [4:0] nh;
  logic [5:0] nm, ns;
  logic close;
  logic [3:0] tl_cl;
  logic [6:0] sum;
  sctc_pkg::bcd_t hb, mb, sb;

  sctc_parse u_parse (.chars(ch_r), .text_length(tl_cl), .is_get(is_get), .is_set(is_set),
    .is_inc(is_inc), .time_ok(tok), .h(ph), .m(pm), .s(ps));

  assign in_tready = st_r == sctc_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;
  assign acc = in_tvalid && in_tready;
  assign out_tvalid = st_r == sctc_pkg::ST_SEND || st_r == sctc_pkg::ST_ERR;
  assign out_tdata = (st_r == sctc_pkg::ST_ERR) ? sctc_pkg::err_char(idx_r) : msg_r[idx_r];
  assign out_tlast = (st_r == sctc_pkg::ST_ERR) ? idx_r == 4'd13 : idx_r == 4'd7;
  assign hb = sctc_pkg::to_bcd({1'b0, hr_r});
  assign mb = sctc_pkg::to_bcd(mn_r);
  assign sb = sctc_pkg::to_bcd(sc_r);

  always_comb begin
    div_inc = div_r + 8'd1;
    tc_inc = tc_r + 8'd1;
    close = 1'b0;
    tl_cl = tl_r;
    if (!in_tuser) close = rcv_r && tc_inc >= to_r;
    else if (rcv_r && fc_r >= sctc_pkg::FrameMaxB) begin
      close = 1'b1;
      if (tl_r > sctc_pkg::TextCut) tl_cl = sctc_pkg::TextCut;
    end
    unique case (step_r)
      2'd0: sum = 7'(sc_r) + 7'(ps);
      2'd1: sum = 7'(mn_r) + 7'(pm) + 7'(cy_r);
      default: sum = 7'(hr_r) + 7'(ph) + 7'(cy_r);
    endcase
  end

  always_comb begin
    nh = hr_r; nm = mn_r; ns = sc_r;
    if (!in_tuser && div_inc >= tps_r) begin
      if (sc_r == 6'd59) begin
        ns = '0;
        if (mn_r == 6'd59) begin
          nm = '0;
          nh = (hr_r == 5'd23) ? 5'd0 : hr_r + 5'd1;
        end else nm = mn_r + 6'd1;
      end else ns = sc_r + 6'd1;
    end
    if (close && is_set && tok) begin
      nh = ph; nm = pm; ns = ps;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sctc_pkg::ST_IDLE: if (acc && close) begin
        if (is_get) st_nxt = sctc_pkg::ST_FMT;
        else if (is_inc && tok) st_nxt = sctc_pkg::ST_ADD;
        else if (!(is_set && tok)) st_nxt = sctc_pkg::ST_ERR;
      end
      sctc_pkg::ST_ADD: if (step_r == 2'd2) st_nxt = sctc_pkg::ST_FMT;
      sctc_pkg::ST_FMT: st_nxt = sctc_pkg::ST_SEND;
      sctc_pkg::ST_SEND: if (out_tready && out_tlast) st_nxt = sctc_pkg::ST_IDLE;
      sctc_pkg::ST_ERR: if (out_tready && out_tlast) st_nxt = sctc_pkg::ST_IDLE;
      default: st_nxt = sctc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sctc_pkg::ST_IDLE;
      tps_r <= sctc_pkg::TpsReset; to_r <= sctc_pkg::ToReset;
      div_r <= '0; fc_r <= '0; tc_r <= '0; hr_r <= '0; mn_r <= '0; sc_r <= '0;
      rcv_r <= 1'b0; ended_r <= 1'b0; tl_r <= '0; step_r <= '0; idx_r <= '0;
      cy_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) begin
        if (cfg_index == sctc_pkg::REG_TPS) tps_r <= cfg_data;
        else to_r <= cfg_data;
      end
      if (acc) begin
        hr_r <= nh; mn_r <= nm; sc_r <= ns;
        if (!in_tuser) begin
          div_r <= (div_inc >= tps_r) ? 8'd0 : div_inc;
          if (rcv_r) tc_r <= tc_inc;
        end
        if (close) begin
          rcv_r <= 1'b0;
          tl_r <= tl_cl;
          idx_r <= '0;
          step_r <= '0;
          cy_r <= 1'b0;
        end else if (in_tuser) begin
          if (!rcv_r) begin
            rcv_r <= 1'b1; tc_r <= '0; fc_r <= 8'd1; tl_r <= '0;
            ended_r <= in_tdata == 8'd0;
            if (in_tdata != 8'd0) begin
              ch_r[0] <= in_tdata; tl_r <= 4'd1;
            end
          end else begin
            fc_r <= fc_r + 8'd1;
            if (!ended_r) begin
              if (in_tdata == 8'd0) ended_r <= 1'b1;
              else begin
                if (tl_r < 4'(sctc_pkg::CmdSlots)) ch_r[tl_r] <= in_tdata;
                if (tl_r != 4'd15) tl_r <= tl_r + 4'd1;
              end
            end
          end
        end
      end
      if (st_r == sctc_pkg::ST_ADD) begin
        step_r <= step_r + 2'd1;
        unique case (step_r)
          2'd0: begin
            cy_r <= sum > 7'd59;
            sc_r <= (sum > 7'd59) ? 6'(sum - 7'd60) : sum[5:0];
          end
          2'd1: begin
            cy_r <= sum > 7'd59;
            mn_r <= (sum > 7'd59) ? 6'(sum - 7'd60) : sum[5:0];
          end
          default: hr_r <= (sum > 7'd23) ? 5'(sum - 7'd24) : sum[4:0];
        endcase
      end
      if (out_tvalid && out_tready) idx_r <= idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == sctc_pkg::ST_FMT) begin
      msg_r[0] <= {4'h3, hb.tens};
      msg_r[1] <= {4'h3, hb.ones};
      msg_r[2] <= ":";
      msg_r[3] <= {4'h3, mb.tens};
      msg_r[4] <= {4'h3, mb.ones};
      msg_r[5] <= ":";
      msg_r[6] <= {4'h3, sb.tens};
      msg_r[7] <= {4'h3, sb.ones};
      msg_r[13:8] <= '0;
    end
  end

  `SCT_ASSERT(a_ready_idle, in_tready |-> !out_tvalid, "ready while sending")
  `SCT_ASSERT(a_time_range, hr_r <= 5'd23 && mn_r <= 6'd59 && sc_r <= 6'd59, "time range")
  `SCT_ASSERT_NEXT(a_fmt_send, st_r == sctc_pkg::ST_FMT, st_r == sctc_pkg::ST_SEND,
    "format must lead to send")
endmodule

// ===== bench/serial_command_time_of_day_clock_test.sv =====
// Testbench for the serial command time-of-day clock: directed and random commands checked.
`timescale 1ns / 1ps
module serial_command_time_of_day_clock_test;

  localparam int unsigned CycleLimit = 2000000;
  localparam logic CmdTick = 1'b0;
  localparam logic CmdByte = 1'b1;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } reply_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_index;
  logic [7:0] cfg_data;

  reply_t     reply_queue[$];
  int         mismatch_count;
  int unsigned cycle_count;

  // Model of the clock and the frame receiver.
  logic [7:0] m_tps, m_timeout;
  logic       m_receiving, m_text_ended;
  logic [7:0] m_frame_count, m_timeout_count, m_divider;
  logic [3:0] m_text_length;
  logic [7:0] m_chars[sctc_pkg::CmdSlots];
  int unsigned m_hours, m_minutes, m_seconds;

  serial_command_time_of_day_clock u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stalls.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (gap_length() == 0) out_tready <= 1'b1;
      else out_tready <= 1'b0;
    end
  end

  always @(posedge clk) begin
    reply_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.tx_byte = out_tdata;
      got.last = out_tlast;
      if (reply_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected reply byte %h last %b", out_tdata, out_tlast);
      end else begin
        want = reply_queue.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("reply mismatch: expected %h/%b got %h/%b",
                     want.tx_byte, want.last, got.tx_byte, got.last);
        end
      end
    end
  end

  function automatic void push_char(logic [7:0] c, logic fin);
    reply_t r;
    r.tx_byte = c;
    r.last = fin;
    reply_queue.push_back(r);
  endfunction

  function automatic void push_time();
    push_char(8'("0" + m_hours / 10), 1'b0);
    push_char(8'("0" + m_hours % 10), 1'b0);
    push_char(":", 1'b0);
    push_char(8'("0" + m_minutes / 10), 1'b0);
    push_char(8'("0" + m_minutes % 10), 1'b0);
    push_char(":", 1'b0);
    push_char(8'("0" + m_seconds / 10), 1'b0);
    push_char(8'("0" + m_seconds % 10), 1'b1);
  endfunction

  function automatic void push_error();
    string s;
    s = "Error Command!";
    for (int i = 0; i < 14; i++) push_char(s[i], i == 13);
  endfunction

  function automatic logic digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic prefix_is(string p);
    for (int i = 0; i < 6; i++)
      if (m_chars[i] != p[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic time_field(output int unsigned h, output int unsigned m,
                                      output int unsigned s);
    if (!digit(m_chars[6]) || !digit(m_chars[7]) || m_chars[8] != ":" ||
        !digit(m_chars[9]) || !digit(m_chars[10]) || m_chars[11] != ":" ||
        !digit(m_chars[12]) || !digit(m_chars[13])) return 1'b0;
    h = (m_chars[6] - "0") * 10 + (m_chars[7] - "0");
    m = (m_chars[9] - "0") * 10 + (m_chars[10] - "0");
    s = (m_chars[12] - "0") * 10 + (m_chars[13] - "0");
    return h <= 23 && m <= 59 && s <= 59;
  endfunction

  function automatic void execute_command();
    int unsigned h, m, s, ss, mm, hh;
    m_receiving = 1'b0;
    if (m_text_length == 6 && prefix_is("AT+GET")) begin
      push_time();
    end else if (m_text_length == 14 && prefix_is("AT+SET")) begin
      if (!time_field(h, m, s)) push_error();
      else begin
        m_hours = h; m_minutes = m; m_seconds = s;
      end
    end else if (m_text_length == 14 && prefix_is("AT+INC")) begin
      if (!time_field(h, m, s)) push_error();
      else begin
        ss = m_seconds + s;
        mm = m_minutes + ss / 60;
        ss = ss % 60;
        mm = mm + m;
        hh = m_hours + mm / 60 + h;
        m_minutes = mm % 60;
        m_hours = hh % 24;
        m_seconds = ss;
        push_time();
      end
    end else begin
      push_error();
    end
  endfunction

  function automatic void store_text(logic [7:0] b);
    if (m_text_ended) return;
    if (b == 8'd0) begin
      m_text_ended = 1'b1;
      return;
    end
    if (m_text_length < sctc_pkg::CmdSlots) m_chars[m_text_length] = b;
    if (m_text_length < 15) m_text_length++;
  endfunction

  function automatic void predict_item(logic cmd, logic [7:0] b);
    if (cmd == CmdTick) begin
      m_divider++;
      if (m_divider >= m_tps) begin
        m_divider = 0;
        m_seconds++;
        if (m_seconds > 59) begin
          m_seconds = 0;
          m_minutes++;
          if (m_minutes > 59) begin
            m_minutes = 0;
            m_hours = (m_hours + 1) % 24;
          end
        end
      end
      if (m_receiving) begin
        m_timeout_count++;
        if (m_timeout_count >= m_timeout) execute_command();
      end
    end else if (!m_receiving) begin
      m_receiving = 1'b1;
      m_timeout_count = 0;
      m_frame_count = 1;
      m_text_length = 0;
      m_text_ended = 1'b0;
      store_text(b);
    end else if (m_frame_count >= sctc_pkg::FrameMax) begin
      if (m_text_length > sctc_pkg::FrameMax - 1) m_text_length = sctc_pkg::TextCut;
      execute_command();
    end else begin
      m_frame_count++;
      store_text(b);
    end
  endfunction

  task automatic send_item(logic cmd, logic [7:0] b);
    repeat (gap_length()) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_item(cmd, b);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(logic idx, logic [7:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == sctc_pkg::REG_TPS) m_tps = value;
    else m_timeout = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A frame of text closed by enough ticks.
  task automatic send_frame(string text);
    for (int i = 0; i < text.len(); i++) send_item(CmdByte, text[i]);
    while (m_receiving) send_item(CmdTick, 8'($urandom()));
  endtask

  function automatic string two_digits(int unsigned v);
    string s;
    s = $sformatf("%0d%0d", v / 10, v % 10);
    return s;
  endfunction

  function automatic string random_time(int unsigned hmax, int unsigned msmax);
    return {two_digits($urandom_range(0, hmax)), ":", two_digits($urandom_range(0, msmax)),
            ":", two_digits($urandom_range(0, msmax))};
  endfunction

  task automatic test_directed();
    send_frame("AT+GET");
    send_frame("AT+SET23:59:59");
    send_frame("AT+GET");
    send_frame("AT+INC23:59:59");
    send_frame("AT+SET24:00:00");
    send_frame("AT+INC00:60:00");
    send_frame("AT+SETab:cd:ef");
    send_frame("AT+GETX");
    send_frame("AT+SET00:00:00X");
  endtask

  task automatic test_long_frames();
    string s;
    // Full frame: the 61st byte closes it and is dropped.
    write_register(sctc_pkg::REG_TO, 8'd3);
    for (int i = 0; i < sctc_pkg::FrameMax + 1; i++) send_item(CmdByte, 8'("A" + i % 20));
    // Zero byte ends the text; later bytes count toward the frame only.
    s = "AT+GET";
    for (int i = 0; i < 6; i++) send_item(CmdByte, s[i]);
    send_item(CmdByte, 8'h00);
    send_item(CmdByte, 8'hFF);
    while (m_receiving) send_item(CmdTick, 8'h00);
  endtask

  task automatic test_ticks();
    write_register(sctc_pkg::REG_TPS, 8'd1);
    write_register(sctc_pkg::REG_TO, 8'd1);
    for (int i = 0; i < 30; i++) send_item(CmdTick, 8'($urandom()));
    send_frame("AT+GET");
    write_register(sctc_pkg::REG_TPS, 8'd255);
    for (int i = 0; i < 20; i++) send_item(CmdTick, 8'($urandom()));
    send_frame("AT+GET");
  endtask

  task automatic test_random(int unsigned count);
    int unsigned sent;
    string s;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: s = {"AT+SET", random_time(23, 59)};
        3, 4, 5: s = {"AT+INC", random_time(23, 59)};
        6: s = {($urandom_range(0, 1) ? "AT+SET" : "AT+INC"), random_time(99, 99)};
        7: s = "AT+GET";
        default: begin
          s = "";
          repeat ($urandom_range(1, 16)) s = {s, string'(8'($urandom_range(1, 255)))};
        end
      endcase
      if ($urandom_range(0, 19) == 0) begin
        wait_drained();
        write_register(sctc_pkg::REG_TPS, 8'($urandom_range(1, 255)));
        write_register(sctc_pkg::REG_TO, 8'($urandom_range(1, 4)));
      end
      for (int i = 0; i < s.len(); i++) send_item(CmdByte, s[i]);
      if ($urandom_range(0, 7) == 0) send_item(CmdByte, 8'($urandom()));
      while (m_receiving) send_item(CmdTick, 8'($urandom()));
      repeat ($urandom_range(0, 3)) send_item(CmdTick, 8'($urandom()));
      sent += s.len() + 3;
    end
    // The sender holds off until every reply has arrived.
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    in_tuser = CmdTick;
    cfg_valid = 1'b0;
    cfg_index = sctc_pkg::REG_TPS;
    cfg_data = 8'h00;
    mismatch_count = 0;
    cycle_count = 0;
    m_tps = sctc_pkg::TpsReset;
    m_timeout = sctc_pkg::ToReset;
    m_receiving = 1'b0;
    m_text_ended = 1'b0;
    m_frame_count = 0;
    m_timeout_count = 0;
    m_divider = 0;
    m_text_length = 0;
    m_hours = 0;
    m_minutes = 0;
    m_seconds = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_long_frames();
    test_ticks();
    test_random(120);
    wait_drained();
    if (mismatch_count == 0 && reply_queue.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== serial_command_time_of_day_clock.f =====
+incdir+sv
sv/sctc_pkg.sv
sv/sctc_parse.sv
sv/serial_command_time_of_day_clock.sv
bench/serial_command_time_of_day_clock_test.sv
